>>> src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the differential-drive odometry block
// Holds the fixed-point constants, the CORDIC arctangent table, the controller
// state type and the command bundle passed from controller to datapath.
// ----------------------------------------------------------------------------
package ddo_pkg;

   // Scaled wheel speed times elapsed microseconds fits in 52 bits of magnitude.
   localparam int MAG_W      = 52;
   // Distance magnitude before the cosine/sine scaling.
   localparam int DM_W       = 42;
   localparam int DM_LO_W    = 20;
   localparam int DM_SHIFT   = 22;
   localparam int CORDIC_W   = 34;
   localparam int IDX_W      = 5;
   localparam int ATAN_N     = 32;

   localparam logic [13:0] DIST_DIV     = 14'd15625;
   localparam logic [25:0] ANGLE_RATE_K = 26'd44798134;
   localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;

   localparam logic [15:0] ENCODER_SCALE_RST  = 16'd655;
   localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd242726;

   typedef enum logic {
      REG_ENCODER_SCALE  = 1'b0,
      REG_INV_WHEEL_BASE = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_RATE,
      ST_TIME,
      ST_ANGLE,
      ST_LOAD,
      ST_ITER,
      ST_DIST,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_ROUND,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             scale;
      logic             rate;
      logic             mul_time;
      logic             angle;
      logic             load_div;
      logic             div_en;
      logic             cordic_en;
      logic [IDX_W-1:0] cordic_idx;
      logic             distance;
      logic             prod_lo;
      logic             prod_hi;
      logic             round;
      logic             commit;
   } cmd_type;

   // atan(2^-i) as a binary angle, 2^32 = two pi.
   function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> src/ddo_req_if.sv
// ----------------------------------------------------------------------------
// ddo_req_if: request channel of the odometry block
// Valid/ready channel carrying the wheel speeds, direction flags and time step.
// ----------------------------------------------------------------------------
interface ddo_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] right_speed_raw;
   logic [15:0] left_speed_raw;
   logic        right_reverse;
   logic        left_reverse;
   logic [19:0] elapsed_us;

   modport source (
      output valid, right_speed_raw, left_speed_raw, right_reverse, left_reverse,
             elapsed_us,
      input  ready
   );
   modport sink (
      input  valid, right_speed_raw, left_speed_raw, right_reverse, left_reverse,
             elapsed_us,
      output ready
   );
endinterface

>>> src/ddo_rsp_if.sv
// ----------------------------------------------------------------------------
// ddo_rsp_if: response channel of the odometry block
// Valid/ready channel carrying the updated pose and the step increments.
// ----------------------------------------------------------------------------
interface ddo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pose_x;
   logic [31:0] pose_y;
   logic [31:0] heading_angle;
   logic [31:0] step_dx;
   logic [31:0] step_dy;
   logic [31:0] step_dheading;

   modport source (
      output valid, pose_x, pose_y, heading_angle, step_dx, step_dy, step_dheading,
      input  ready
   );
   modport sink (
      input  valid, pose_x, pose_y, heading_angle, step_dx, step_dy, step_dheading,
      output ready
   );
endinterface

>>> src/ddo_csr.sv
// ----------------------------------------------------------------------------
// ddo_csr: configuration registers
// APB-style register file holding the encoder scale and reciprocal wheel base.
// ----------------------------------------------------------------------------
module ddo_csr
   import ddo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [15:0] encoder_scale,
   output logic [23:0] inv_wheel_base
);

   logic [15:0] scale_ff, scale_in;
   logic [23:0] iwb_ff, iwb_in;
   csr_idx_type idx;
   logic        wr;

   assign idx    = csr_idx_type'(paddr[2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      scale_in = scale_ff;
      iwb_in   = iwb_ff;
      if (wr) begin
         unique case (idx)
            REG_ENCODER_SCALE:  scale_in = pwdata[15:0];
            REG_INV_WHEEL_BASE: iwb_in   = pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ENCODER_SCALE:  prdata = {16'd0, scale_ff};
         REG_INV_WHEEL_BASE: prdata = {8'd0, iwb_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ENCODER_SCALE_RST;
         iwb_ff   <= INV_WHEEL_BASE_RST;
      end else begin
         scale_ff <= scale_in;
         iwb_ff   <= iwb_in;
      end
   end

   assign encoder_scale  = scale_ff;
   assign inv_wheel_base = iwb_ff;

endmodule

>>> src/ddo_dp.sv
// ----------------------------------------------------------------------------
// ddo_dp: odometry datapath
// Wheel scaling, turn and distance products, radix-4 constant divider,
// iterative CORDIC, rounding, saturation and the pose accumulators.
// ----------------------------------------------------------------------------
module ddo_dp
   import ddo_pkg::*;
#(
   parameter int POSITION_FRAC_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [15:0] encoder_scale,
   input  logic [23:0] inv_wheel_base,
   input  logic [15:0] right_speed_raw,
   input  logic [15:0] left_speed_raw,
   input  logic        right_reverse,
   input  logic        left_reverse,
   input  logic [19:0] elapsed_us,
   output logic [31:0] pose_x,
   output logic [31:0] pose_y,
   output logic [31:0] heading_angle,
   output logic [31:0] step_dx,
   output logic [31:0] step_dy,
   output logic [31:0] step_dheading
);

   localparam int DIV_STEPS = (MAG_W + POSITION_FRAC_BITS + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int RND_W     = DIV_W + 23;

   // Item fields
   logic [15:0] raw_r_ff, raw_l_ff;
   logic        rev_r_ff, rev_l_ff;
   logic [19:0] us_ff;

   // Products and intermediates
   logic signed [32:0] vr_ff, vr_in, vl_ff, vl_in;
   logic signed [32:0] v_ff, v_in;
   logic signed [41:0] t1_ff, t1_in;
   logic signed [53:0] pv_ff, pv_in;
   logic [63:0]        t2_ff, t2_in;
   logic [57:0]        plo_ff, plo_in;
   logic [31:0]        phi_ff, phi_in;
   logic [31:0]        dh_ff, dh_in;
   logic               neg_d_ff, neg_d_in;

   // Divider
   logic [DIV_W-1:0]   num_ff, num_in, quo_ff, quo_in;
   logic [13:0]        rem_ff, rem_in;

   // CORDIC
   logic signed [CORDIC_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                       flip_ff, flip_in;

   // Scaling
   logic [DM_W-1:0]    dm_ff, dm_in;
   logic [32:0]        cmag_ff, cmag_in, smag_ff, smag_in;
   logic               neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [52:0]        pxl_ff, pxl_in, pyl_ff, pyl_in;
   logic [54:0]        pxh_ff, pxh_in, pyh_ff, pyh_in;
   logic [31:0]        dx_ff, dx_in, dy_ff, dy_in;

   // Accumulators and result registers
   logic [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, head_ff, head_in;
   logic [31:0] out_dx_ff, out_dy_ff, out_dh_ff;

   // Combinational helpers
   logic [31:0]        prod_r, prod_l;
   logic signed [33:0] vsum, vdiff;
   logic signed [58:0] rate_prod;
   logic signed [20:0] us_s;
   logic signed [62:0] t2_prod;
   logic [57:0]        phi_full;
   logic [58:0]        plo_rnd;
   logic [53:0]        pv_abs;
   logic [15:0]        div_t;
   logic [1:0]         digit;
   logic [15:0]        rem_next;
   logic [31:0]        fold_sum, fold_ang;
   logic signed [CORDIC_W-1:0] xs, ys, at;
   logic [RND_W-1:0]   xr;
   logic signed [CORDIC_W-1:0] cval, sval;
   logic [75:0]        fx, fy;
   logic [45:0]        mx, my;
   logic signed [32:0] sumx, sumy;

   function automatic logic [31:0] sat_mag(input logic neg, input logic [45:0] m);
      logic [31:0] r;
      if (neg) begin
         if (m > 46'h0_8000_0000) r = 32'h8000_0000;
         else                    r = 32'd0 - m[31:0];
      end else begin
         if (m > 46'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
         else                    r = m[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_add(input logic signed [32:0] s);
      logic [31:0] r;
      if (s > 33'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (s < -33'sd2147483648) r = 32'h8000_0000;
      else                           r = s[31:0];
      return r;
   endfunction

   always_comb begin
      // Wheel speeds
      prod_r = raw_r_ff * encoder_scale;
      prod_l = raw_l_ff * encoder_scale;
      vr_in  = rev_r_ff ? -$signed({1'b0, prod_r}) : $signed({1'b0, prod_r});
      vl_in  = rev_l_ff ? -$signed({1'b0, prod_l}) : $signed({1'b0, prod_l});

      // Mean speed and turn rate
      vsum      = {vr_ff[32], vr_ff} + {vl_ff[32], vl_ff};
      vdiff     = {vr_ff[32], vr_ff} - {vl_ff[32], vl_ff};
      v_in      = vsum[33:1];
      rate_prod = vdiff * $signed({1'b0, inv_wheel_base});
      t1_in     = rate_prod[57:16];

      // Time products
      us_s    = $signed({1'b0, us_ff});
      pv_in   = v_ff * us_s;
      t2_prod = t1_ff * us_s;
      t2_in   = {t2_prod[62], t2_prod};

      // Heading increment, low 64 bits of t2 * K split at bit 32
      plo_in   = t2_ff[31:0] * ANGLE_RATE_K;
      phi_full = t2_ff[63:32] * ANGLE_RATE_K;
      phi_in   = phi_full[31:0];
      plo_rnd  = {1'b0, plo_ff} + 59'h0_8000_0000;
      dh_in    = phi_ff + {5'd0, plo_rnd[58:32]};

      pv_abs   = pv_ff[53] ? 54'd0 - pv_ff : pv_ff;
      neg_d_in = pv_ff[53];

      // Radix-4 restoring division by a constant
      div_t = {rem_ff, num_ff[DIV_W-1 -: 2]};
      if (div_t >= 16'(3 * DIST_DIV)) begin
         digit    = 2'd3;
         rem_next = div_t - 16'(3 * DIST_DIV);
      end else if (div_t >= 16'(2 * DIST_DIV)) begin
         digit    = 2'd2;
         rem_next = div_t - 16'(2 * DIST_DIV);
      end else if (div_t >= 16'(DIST_DIV)) begin
         digit    = 2'd1;
         rem_next = div_t - 16'(DIST_DIV);
      end else begin
         digit    = 2'd0;
         rem_next = div_t;
      end

      // Fold the heading into [-pi/2, pi/2) by a half turn.
      fold_sum = head_ff + 32'h4000_0000;
      fold_ang = fold_sum[31] ? head_ff - 32'h8000_0000 : head_ff;

      xs = cx_ff >>> cmd.cordic_idx;
      ys = cy_ff >>> cmd.cordic_idx;
      at = $signed({2'b00, atan_entry(cmd.cordic_idx)});

      // Distance rounding and signs of the two products
      xr    = RND_W'(quo_ff) + RND_W'(22'h20_0000);
      dm_in = xr[DM_SHIFT +: DM_W];
      cval  = flip_ff ? -cx_ff : cx_ff;
      sval  = flip_ff ? -cy_ff : cy_ff;
      neg_x_in = neg_d_ff ^ cval[CORDIC_W-1];
      neg_y_in = neg_d_ff ^ sval[CORDIC_W-1];
      cmag_in  = cval[CORDIC_W-1] ? 33'(-cval) : 33'(cval);
      smag_in  = sval[CORDIC_W-1] ? 33'(-sval) : 33'(sval);

      pxl_in = dm_ff[DM_LO_W-1:0] * cmag_ff;
      pyl_in = dm_ff[DM_LO_W-1:0] * smag_ff;
      pxh_in = dm_ff[DM_W-1:DM_LO_W] * cmag_ff;
      pyh_in = dm_ff[DM_W-1:DM_LO_W] * smag_ff;

      fx    = {1'b0, pxh_ff, 20'd0} + 76'(pxl_ff) + 76'h2000_0000;
      fy    = {1'b0, pyh_ff, 20'd0} + 76'(pyl_ff) + 76'h2000_0000;
      mx    = fx[75:30];
      my    = fy[75:30];
      dx_in = sat_mag(neg_x_ff, mx);
      dy_in = sat_mag(neg_y_ff, my);

      sumx     = {pos_x_ff[31], pos_x_ff} + {dx_ff[31], dx_ff};
      sumy     = {pos_y_ff[31], pos_y_ff} + {dy_ff[31], dy_ff};
      pos_x_in = sat_add(sumx);
      pos_y_in = sat_add(sumy);
      head_in  = head_ff + dh_ff;

      // Next values of the divider and the CORDIC
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      flip_in = flip_ff;
      if (cmd.load_div) begin
         num_in  = DIV_W'({pv_abs[MAG_W-1:0], {POSITION_FRAC_BITS{1'b0}}});
         quo_in  = '0;
         rem_in  = '0;
         cx_in   = $signed(CORDIC_GAIN);
         cy_in   = '0;
         cz_in   = $signed({{(CORDIC_W-32){fold_ang[31]}}, fold_ang});
         flip_in = fold_sum[31];
      end else begin
         if (cmd.div_en) begin
            num_in = {num_ff[DIV_W-3:0], 2'b00};
            quo_in = {quo_ff[DIV_W-3:0], digit};
            rem_in = rem_next[13:0];
         end
         if (cmd.cordic_en) begin
            if (!cz_ff[CORDIC_W-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_r_ff <= right_speed_raw;
         raw_l_ff <= left_speed_raw;
         rev_r_ff <= right_reverse;
         rev_l_ff <= left_reverse;
         us_ff    <= elapsed_us;
      end
      if (cmd.scale) begin
         vr_ff <= vr_in;
         vl_ff <= vl_in;
      end
      if (cmd.rate) begin
         v_ff  <= v_in;
         t1_ff <= t1_in;
      end
      if (cmd.mul_time) begin
         pv_ff <= pv_in;
         t2_ff <= t2_in;
      end
      if (cmd.angle) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (cmd.load_div) begin
         dh_ff    <= dh_in;
         neg_d_ff <= neg_d_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      flip_ff <= flip_in;
      if (cmd.distance) begin
         dm_ff    <= dm_in;
         cmag_ff  <= cmag_in;
         smag_ff  <= smag_in;
         neg_x_ff <= neg_x_in;
         neg_y_ff <= neg_y_in;
      end
      if (cmd.prod_lo) begin
         pxl_ff <= pxl_in;
         pyl_ff <= pyl_in;
      end
      if (cmd.prod_hi) begin
         pxh_ff <= pxh_in;
         pyh_ff <= pyh_in;
      end
      if (cmd.round) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.commit) begin
         out_dx_ff <= dx_ff;
         out_dy_ff <= dy_ff;
         out_dh_ff <= dh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         head_ff  <= '0;
      end else if (cmd.commit) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff  <= head_in;
      end
   end

   // Apart from reset, the pose only changes at a commit, which waits for the previous response.
   assign pose_x        = pos_x_ff;
   assign pose_y        = pos_y_ff;
   assign heading_angle = head_ff;
   assign step_dx       = out_dx_ff;
   assign step_dy       = out_dy_ff;
   assign step_dheading = out_dh_ff;

endmodule

>>> src/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl: odometry sequencer
// State machine that steps the datapath through one request and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module ddo_ctrl
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS       = 24,
   parameter int POSITION_FRAC_BITS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam int DIV_STEPS = (MAG_W + POSITION_FRAC_BITS + 1) / 2;
   localparam int ITER      = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
   localparam int CNT_W     = $clog2(ITER + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_RATE;
         ST_RATE:    state_in = ST_TIME;
         ST_TIME:    state_in = ST_ANGLE;
         ST_ANGLE:   state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_ITER;
         ST_ITER:    if (cnt_ff == CNT_W'(ITER - 1)) state_in = ST_DIST;
         ST_DIST:    state_in = ST_PROD_LO;
         ST_PROD_LO: state_in = ST_PROD_HI;
         ST_PROD_HI: state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_COMMIT;
         ST_COMMIT:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.cordic_idx = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCALE:   cmd.scale    = 1'b1;
         ST_RATE:    cmd.rate     = 1'b1;
         ST_TIME:    cmd.mul_time = 1'b1;
         ST_ANGLE:   cmd.angle    = 1'b1;
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            cnt_in       = '0;
         end
         ST_ITER: begin
            cmd.div_en    = cnt_ff < CNT_W'(DIV_STEPS);
            cmd.cordic_en = cnt_ff < CNT_W'(CORDIC_STEPS);
            cnt_in        = cnt_ff + 1'b1;
         end
         ST_DIST:    cmd.distance = 1'b1;
         ST_PROD_LO: cmd.prod_lo  = 1'b1;
         ST_PROD_HI: cmd.prod_hi  = 1'b1;
         ST_ROUND:   cmd.round    = 1'b1;
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A commit never overwrites a response that has not been taken.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while response still pending");

   // An accepted request starts the sequence in the next cycle.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCALE))
      else $error("accepted request did not start the sequence");

   // The iteration count starts from zero.
   a_iter_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (cnt_ff == '0 && state_ff == ST_ITER))
      else $error("iteration count not cleared");

   // A commit always raises the response valid.
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise response valid");

endmodule

>>> src/diff_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_top: dead-reckoning pose tracker for a two-wheel robot
// ----------------------------------------------------------------------------
// A request on req_bus carries both raw wheel speeds, their reverse flags and
// the elapsed time in microseconds. For each request one response appears on
// rsp_bus with the new pose (x, y, heading) and the increments of this step.
// The encoder scale and reciprocal wheel base are written over the APB-style
// port (byte addresses 0 and 4); the user must write them only while no
// request is in flight; the block itself does not enforce this. A request
// is taken only while the sequencer is idle. It then runs the scale, rate,
// time, angle and load steps, the shared iteration loop, in which the
// radix-4 distance divider (DIV_STEPS = (52 + POSITION_FRAC_BITS + 1) / 2)
// and the CORDIC step together until both finish, then the distance, two
// product, round and commit steps. The response sits in an output register,
// so a new request is taken while it waits; if the receiver still stalls when
// the next result is ready, the sequencer holds until that response is taken.
// Reset clears the pose and heading to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry_top
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS       = 24,
   parameter int POSITION_FRAC_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   ddo_req_if.sink      req_bus,
   ddo_rsp_if.source    rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   cmd_type     cmd;
   logic [15:0] encoder_scale;
   logic [23:0] inv_wheel_base;

   ddo_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .encoder_scale  (encoder_scale),
      .inv_wheel_base (inv_wheel_base)
   );

   ddo_ctrl #(
      .CORDIC_STEPS       (CORDIC_STEPS),
      .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   ddo_dp #(
      .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .encoder_scale   (encoder_scale),
      .inv_wheel_base  (inv_wheel_base),
      .right_speed_raw (req_bus.right_speed_raw),
      .left_speed_raw  (req_bus.left_speed_raw),
      .right_reverse   (req_bus.right_reverse),
      .left_reverse    (req_bus.left_reverse),
      .elapsed_us      (req_bus.elapsed_us),
      .pose_x          (rsp_bus.pose_x),
      .pose_y          (rsp_bus.pose_y),
      .heading_angle   (rsp_bus.heading_angle),
      .step_dx         (rsp_bus.step_dx),
      .step_dy         (rsp_bus.step_dy),
      .step_dheading   (rsp_bus.step_dheading)
   );

endmodule
